@@ rtl/fjvs_pkg.sv @@
// shared types, codes and helpers of the fixed joint velocity solver
package fjvs_pkg;

  localparam int Q_W        = 32;
  localparam int ANGLE_W    = 16;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int DIV_NUM_W  = 48;
  localparam int DIV_DEN_W  = 32;

  typedef logic signed [Q_W-1:0] q_t;

  localparam logic [CMD_W-1:0] CMD_WARM   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SOLVE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS_1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS_2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_INERTIA_1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_INERTIA_2 = 3'd5;

  localparam q_t QS_A  = 32'sd102944;
  localparam q_t QS_B  = 32'sd42334;
  localparam q_t QS_C  = 32'sd4926;
  localparam q_t Q_MAX = 32'sh7fffffff;
  localparam q_t Q_MIN = 32'sh80000000;

  typedef enum logic [5:0] {
    S_IDLE, S_E_START, S_E_WAIT, S_E_RND,
    S_W1, S_W2,
    S_T0, S_T1, S_T2, S_T3, S_T4,
    S_L1, S_L2, S_L3, S_L4,
    S_W3, S_W4, S_W5, S_W6, S_W7, S_W8, S_W9,
    S_S1, S_S2, S_S3, S_S4, S_S5,
    S_S6, S_S7, S_S8, S_S9, S_S10, S_S11, S_S12, S_S13, S_S14, S_S15,
    S_DX_START, S_DX_WAIT, S_DY_START, S_DY_WAIT,
    S_S20, S_S21, S_S22, S_S23, S_S24, S_S25, S_S26, S_S27, S_S28, S_S29,
    S_TQ
  } step_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic q_t sat_q(input logic signed [48:0] v);
    if (v > 49'sd2147483647) begin
      return Q_MAX;
    end else if (v < -49'sd2147483648) begin
      return Q_MIN;
    end
    return v[31:0];
  endfunction

endpackage

@@ rtl/fjvs_div.sv @@
// restoring unsigned divider, one quotient bit per cycle
module fjvs_div #(
  parameter int NUM_W = fjvs_pkg::DIV_NUM_W,
  parameter int DEN_W = fjvs_pkg::DIV_DEN_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_W-1:0]    num,
  input  logic [DEN_W-1:0]    den,
  output fjvs_pkg::div_stat_t stat,
  output logic [NUM_W-1:0]    quo,
  output logic [DEN_W-1:0]    rem
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign trial   = shifted - {1'b0, den_r};
  assign fits    = !trial[DEN_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        quo_r <= {quo_r[NUM_W-2:0], fits};
        rem_r <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;
  assign rem       = rem_r;

endmodule

@@ rtl/fixed_joint_velocity_solver_top.sv @@
// fixed joint velocity solver: sequencer around one multiply-add unit and a divider
//
//  channel | direction | handshake           | payload
//  in_     | slave     | in_tvalid/in_tready | tdata velocities and angle, tuser cmd
//  out_    | master    | out_tvalid/out_tready | tdata velocities and impulses
//  cfg_    | slave     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// the divider wait (at most once per begin step, at most twice per solve) sets most of the work time,
// the rest is one multiply-add step per cycle; an unused command goes straight to the output step,
// and the sequencer returns to idle after each item before the next can be accepted
// reset puts the sequencer in idle and clears output valid, configuration registers and accumulators
// in_tready is high only in idle; a finished beat waits in the output register
// and the sequencer holds in its last step while that register is still full
module fixed_joint_velocity_solver_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // body1_vel_x, body1_vel_y, body1_spin, body2_vel_x, body2_vel_y, body2_spin,
  // body1_angle
  input  logic [207:0] in_tdata,
  // cmd
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // new_body1_vel_x, new_body1_vel_y, new_body1_spin, new_body2_vel_x,
  // new_body2_vel_y, new_body2_spin, impulse_x, impulse_y, impulse_torque
  output logic [287:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  fjvs_pkg::step_t state_r, state_nxt;

  fjvs_pkg::q_t off_x_r, off_y_r;
  logic [30:0]  im1_r, im2_r, ii1_r, ii2_r;
  fjvs_pkg::q_t v1x_r, v1y_r, w1_r, v2x_r, v2y_r, w2_r;
  logic [15:0]  ang_r;
  logic [1:0]   cmd_r;
  fjvs_pkg::q_t acc_ang_r, alx_r, aly_r, alev_r, eff_r;
  fjvs_pkg::q_t t0_r, t1_r, t2_r, t3_r, sn_r, cs_r, ax_r, ay_r, la_r, lx_r, ly_r;
  logic [16:0]  x_r;
  logic         neg_r, cos_r;
  logic [287:0] out_data_r;
  logic         out_valid_r;

  fjvs_pkg::q_t im1_q, im2_q, ii1_q, ii2_q, xq;
  fjvs_pkg::q_t ma, mb, add_aa, add_ab, add_b_src, mul_res, add_res;
  logic         mul_rnd, add_na, add_nb, use_mul;
  logic signed [63:0] mul_p;
  logic signed [64:0] mul_pr;
  logic signed [48:0] mul_sh;
  logic signed [33:0] add_a_ext, add_b_ext, add_s;

  logic         div_start;
  logic [47:0]  div_num, div_quo;
  logic [31:0]  div_den, div_rem;
  fjvs_pkg::div_stat_t div_stat;

  logic [31:0]  isum, mag_x, mag_y;
  logic         neg_x, neg_y, round_up, out_free, in_acc;
  logic [48:0]  eff_q1;
  fjvs_pkg::q_t eff_val;
  logic [15:0]  trig_a;
  logic [14:0]  trig_f;

  function automatic fjvs_pkg::q_t qdiv_sat(input logic [47:0] q, input logic neg);
    if (neg) begin
      if (q >= 48'h0000_8000_0000) begin
        return fjvs_pkg::Q_MIN;
      end
      return ~q[31:0] + 32'd1;
    end
    if (q > 48'h0000_7fff_ffff) begin
      return fjvs_pkg::Q_MAX;
    end
    return q[31:0];
  endfunction

  assign im1_q = {1'b0, im1_r};
  assign im2_q = {1'b0, im2_r};
  assign ii1_q = {1'b0, ii1_r};
  assign ii2_q = {1'b0, ii2_r};
  assign xq    = {15'b0, x_r};

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // shared multiply-add unit
  assign mul_p     = ma * mb;
  assign mul_pr    = 65'(mul_p) + (mul_rnd ? 65'sd32768 : 65'sd0);
  assign mul_sh    = mul_pr[64:16];
  assign mul_res   = fjvs_pkg::sat_q(mul_sh);
  assign add_b_src = use_mul ? mul_res : add_ab;
  assign add_a_ext = add_na ? -34'(add_aa) : 34'(add_aa);
  assign add_b_ext = add_nb ? -34'(add_b_src) : 34'(add_b_src);
  assign add_s     = add_a_ext + add_b_ext;
  assign add_res   = fjvs_pkg::sat_q(49'(add_s));

  // divider operands and results
  assign isum     = {1'b0, ii1_r} + {1'b0, ii2_r};
  assign round_up = {div_rem, 1'b0} >= {1'b0, isum};
  assign eff_q1   = {1'b0, div_quo} + 49'(round_up);
  assign eff_val  = (eff_q1 > 49'h0_7fff_ffff) ? fjvs_pkg::Q_MAX : eff_q1[31:0];
  assign mag_x    = t0_r[31] ? (~t0_r + 32'd1) : t0_r;
  assign mag_y    = t1_r[31] ? (~t1_r + 32'd1) : t1_r;
  assign neg_x    = !t0_r[31] && (t0_r != 32'sd0);
  assign neg_y    = !t1_r[31] && (t1_r != 32'sd0);

  // quarter-wave argument
  assign trig_a = ang_r + (cos_r ? 16'd16384 : 16'd0);
  assign trig_f = trig_a[14] ? (15'd16384 - {1'b0, trig_a[13:0]}) : {1'b0, trig_a[13:0]};

  fjvs_div #(
    .NUM_W (fjvs_pkg::DIV_NUM_W),
    .DEN_W (fjvs_pkg::DIV_DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fjvs_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == fjvs_pkg::CMD_WARM || in_tuser == fjvs_pkg::CMD_CLEAR) begin
            state_nxt = fjvs_pkg::S_E_START;
          end else if (in_tuser == fjvs_pkg::CMD_SOLVE) begin
            state_nxt = fjvs_pkg::S_S1;
          end else begin
            state_nxt = fjvs_pkg::S_TQ;
          end
        end
      end
      fjvs_pkg::S_E_START: state_nxt = (isum != 32'd0) ? fjvs_pkg::S_E_WAIT : fjvs_pkg::S_E_RND;
      fjvs_pkg::S_E_WAIT: begin
        if (div_stat.done) state_nxt = fjvs_pkg::S_E_RND;
      end
      fjvs_pkg::S_E_RND: begin
        state_nxt = (cmd_r == fjvs_pkg::CMD_CLEAR) ? fjvs_pkg::S_TQ : fjvs_pkg::S_W1;
      end
      fjvs_pkg::S_W1:  state_nxt = fjvs_pkg::S_W2;
      fjvs_pkg::S_W2:  state_nxt = fjvs_pkg::S_T0;
      fjvs_pkg::S_T0:  state_nxt = fjvs_pkg::S_T1;
      fjvs_pkg::S_T1:  state_nxt = fjvs_pkg::S_T2;
      fjvs_pkg::S_T2:  state_nxt = fjvs_pkg::S_T3;
      fjvs_pkg::S_T3:  state_nxt = fjvs_pkg::S_T4;
      fjvs_pkg::S_T4:  state_nxt = cos_r ? fjvs_pkg::S_L1 : fjvs_pkg::S_T0;
      fjvs_pkg::S_L1:  state_nxt = fjvs_pkg::S_L2;
      fjvs_pkg::S_L2:  state_nxt = fjvs_pkg::S_L3;
      fjvs_pkg::S_L3:  state_nxt = fjvs_pkg::S_L4;
      fjvs_pkg::S_L4: begin
        state_nxt = (cmd_r == fjvs_pkg::CMD_SOLVE) ? fjvs_pkg::S_S6 : fjvs_pkg::S_W3;
      end
      fjvs_pkg::S_W3:  state_nxt = fjvs_pkg::S_W4;
      fjvs_pkg::S_W4:  state_nxt = fjvs_pkg::S_W5;
      fjvs_pkg::S_W5:  state_nxt = fjvs_pkg::S_W6;
      fjvs_pkg::S_W6:  state_nxt = fjvs_pkg::S_W7;
      fjvs_pkg::S_W7:  state_nxt = fjvs_pkg::S_W8;
      fjvs_pkg::S_W8:  state_nxt = fjvs_pkg::S_W9;
      fjvs_pkg::S_W9:  state_nxt = fjvs_pkg::S_TQ;
      fjvs_pkg::S_S1:  state_nxt = fjvs_pkg::S_S2;
      fjvs_pkg::S_S2:  state_nxt = fjvs_pkg::S_S3;
      fjvs_pkg::S_S3:  state_nxt = fjvs_pkg::S_S4;
      fjvs_pkg::S_S4:  state_nxt = fjvs_pkg::S_S5;
      fjvs_pkg::S_S5:  state_nxt = fjvs_pkg::S_T0;
      fjvs_pkg::S_S6:  state_nxt = fjvs_pkg::S_S7;
      fjvs_pkg::S_S7:  state_nxt = fjvs_pkg::S_S8;
      fjvs_pkg::S_S8:  state_nxt = fjvs_pkg::S_S9;
      fjvs_pkg::S_S9:  state_nxt = fjvs_pkg::S_S10;
      fjvs_pkg::S_S10: state_nxt = fjvs_pkg::S_S11;
      fjvs_pkg::S_S11: state_nxt = fjvs_pkg::S_S12;
      fjvs_pkg::S_S12: state_nxt = fjvs_pkg::S_S13;
      fjvs_pkg::S_S13: state_nxt = fjvs_pkg::S_S14;
      fjvs_pkg::S_S14: state_nxt = fjvs_pkg::S_S15;
      fjvs_pkg::S_S15: state_nxt = fjvs_pkg::S_DX_START;
      fjvs_pkg::S_DX_START: begin
        state_nxt = (t2_r > 32'sd0) ? fjvs_pkg::S_DX_WAIT : fjvs_pkg::S_DY_START;
      end
      fjvs_pkg::S_DX_WAIT: begin
        if (div_stat.done) state_nxt = fjvs_pkg::S_DY_START;
      end
      fjvs_pkg::S_DY_START: begin
        state_nxt = (t3_r > 32'sd0) ? fjvs_pkg::S_DY_WAIT : fjvs_pkg::S_S20;
      end
      fjvs_pkg::S_DY_WAIT: begin
        if (div_stat.done) state_nxt = fjvs_pkg::S_S20;
      end
      fjvs_pkg::S_S20: state_nxt = fjvs_pkg::S_S21;
      fjvs_pkg::S_S21: state_nxt = fjvs_pkg::S_S22;
      fjvs_pkg::S_S22: state_nxt = fjvs_pkg::S_S23;
      fjvs_pkg::S_S23: state_nxt = fjvs_pkg::S_S24;
      fjvs_pkg::S_S24: state_nxt = fjvs_pkg::S_S25;
      fjvs_pkg::S_S25: state_nxt = fjvs_pkg::S_S26;
      fjvs_pkg::S_S26: state_nxt = fjvs_pkg::S_S27;
      fjvs_pkg::S_S27: state_nxt = fjvs_pkg::S_S28;
      fjvs_pkg::S_S28: state_nxt = fjvs_pkg::S_S29;
      fjvs_pkg::S_S29: state_nxt = fjvs_pkg::S_TQ;
      fjvs_pkg::S_TQ: begin
        if (out_free) state_nxt = fjvs_pkg::S_IDLE;
      end
      default: state_nxt = fjvs_pkg::S_IDLE;
    endcase
  end

  // operand selection for the shared unit and the divider
  always_comb begin
    ma        = '0;
    mb        = '0;
    mul_rnd   = 1'b1;
    add_aa    = '0;
    add_ab    = '0;
    add_na    = 1'b0;
    add_nb    = 1'b0;
    use_mul   = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_r)
      fjvs_pkg::S_E_START: begin
        div_start = (isum != 32'd0);
        div_num   = 48'h0001_0000_0000;
        div_den   = isum;
      end
      fjvs_pkg::S_W1: begin
        ma = ii1_q; mb = acc_ang_r; add_aa = w1_r; use_mul = 1'b1; add_nb = 1'b1;
      end
      fjvs_pkg::S_W2: begin
        ma = ii2_q; mb = acc_ang_r; add_aa = w2_r; use_mul = 1'b1;
      end
      fjvs_pkg::S_T1: begin
        mul_rnd = 1'b0; ma = xq; mb = xq; use_mul = 1'b1;
      end
      fjvs_pkg::S_T2: begin
        mul_rnd = 1'b0; ma = t0_r; mb = fjvs_pkg::QS_C; add_aa = fjvs_pkg::QS_B;
        use_mul = 1'b1; add_nb = 1'b1;
      end
      fjvs_pkg::S_T3: begin
        mul_rnd = 1'b0; ma = t0_r; mb = t1_r; add_aa = fjvs_pkg::QS_A;
        use_mul = 1'b1; add_nb = 1'b1;
      end
      fjvs_pkg::S_T4: begin
        mul_rnd = 1'b0; ma = xq; mb = t1_r; use_mul = 1'b1; add_nb = neg_r;
      end
      fjvs_pkg::S_L1: begin
        ma = sn_r; mb = off_x_r; use_mul = 1'b1;
      end
      fjvs_pkg::S_L2: begin
        ma = cs_r; mb = off_y_r; add_aa = t0_r; add_na = 1'b1; use_mul = 1'b1; add_nb = 1'b1;
      end
      fjvs_pkg::S_L3: begin
        ma = cs_r; mb = off_x_r; use_mul = 1'b1;
      end
      fjvs_pkg::S_L4: begin
        ma = sn_r; mb = off_y_r; add_aa = t0_r; use_mul = 1'b1; add_nb = 1'b1;
      end
      fjvs_pkg::S_W3: begin
        ma = im1_q; mb = alx_r; add_aa = v1x_r; use_mul = 1'b1; add_nb = 1'b1;
      end
      fjvs_pkg::S_W4: begin
        ma = im1_q; mb = aly_r; add_aa = v1y_r; use_mul = 1'b1; add_nb = 1'b1;
      end
      fjvs_pkg::S_W5: begin
        ma = alx_r; mb = ax_r; use_mul = 1'b1;
      end
      fjvs_pkg::S_W6: begin
        ma = aly_r; mb = ay_r; add_aa = t0_r; use_mul = 1'b1;
      end
      fjvs_pkg::S_W7: begin
        ma = ii1_q; mb = t0_r; add_aa = w1_r; use_mul = 1'b1; add_nb = 1'b1;
      end
      fjvs_pkg::S_W8: begin
        ma = im2_q; mb = alx_r; add_aa = v2x_r; use_mul = 1'b1;
      end
      fjvs_pkg::S_W9: begin
        ma = im2_q; mb = aly_r; add_aa = v2y_r; use_mul = 1'b1;
      end
      fjvs_pkg::S_S1: begin
        add_aa = w2_r; add_ab = w1_r; add_nb = 1'b1;
      end
      fjvs_pkg::S_S2: begin
        ma = eff_r; mb = t0_r; use_mul = 1'b1; add_nb = 1'b1;
      end
      fjvs_pkg::S_S3: begin
        add_aa = acc_ang_r; add_ab = la_r;
      end
      fjvs_pkg::S_S4: begin
        ma = ii1_q; mb = la_r; add_aa = w1_r; use_mul = 1'b1; add_nb = 1'b1;
      end
      fjvs_pkg::S_S5: begin
        ma = ii2_q; mb = la_r; add_aa = w2_r; use_mul = 1'b1;
      end
      fjvs_pkg::S_S6: begin
        add_aa = v2x_r; add_ab = v1x_r; add_nb = 1'b1;
      end
      fjvs_pkg::S_S7: begin
        ma = w1_r; mb = ax_r; add_aa = t0_r; use_mul = 1'b1; add_nb = 1'b1;
      end
      fjvs_pkg::S_S8: begin
        add_aa = v2y_r; add_ab = v1y_r; add_nb = 1'b1;
      end
      fjvs_pkg::S_S9: begin
        ma = w1_r; mb = ay_r; add_aa = t1_r; use_mul = 1'b1; add_nb = 1'b1;
      end
      fjvs_pkg::S_S10: begin
        ma = ii1_q; mb = ax_r; use_mul = 1'b1;
      end
      fjvs_pkg::S_S11: begin
        ma = t2_r; mb = ax_r; add_aa = im1_q; use_mul = 1'b1;
      end
      fjvs_pkg::S_S12: begin
        add_aa = t2_r; add_ab = im2_q;
      end
      fjvs_pkg::S_S13: begin
        ma = ii1_q; mb = ay_r; use_mul = 1'b1;
      end
      fjvs_pkg::S_S14: begin
        ma = t3_r; mb = ay_r; add_aa = im1_q; use_mul = 1'b1;
      end
      fjvs_pkg::S_S15: begin
        add_aa = t3_r; add_ab = im2_q;
      end
      fjvs_pkg::S_DX_START: begin
        div_start = (t2_r > 32'sd0);
        div_num   = {mag_x, 16'b0} + {17'b0, t2_r[31:1]};
        div_den   = t2_r;
      end
      fjvs_pkg::S_DY_START: begin
        div_start = (t3_r > 32'sd0);
        div_num   = {mag_y, 16'b0} + {17'b0, t3_r[31:1]};
        div_den   = t3_r;
      end
      fjvs_pkg::S_S20: begin
        add_aa = alx_r; add_ab = lx_r;
      end
      fjvs_pkg::S_S21: begin
        add_aa = aly_r; add_ab = ly_r;
      end
      fjvs_pkg::S_S22: begin
        ma = ax_r; mb = lx_r; use_mul = 1'b1;
      end
      fjvs_pkg::S_S23: begin
        ma = ay_r; mb = ly_r; add_aa = t0_r; use_mul = 1'b1;
      end
      fjvs_pkg::S_S24: begin
        add_aa = alev_r; add_ab = t0_r;
      end
      fjvs_pkg::S_S25: begin
        ma = im1_q; mb = lx_r; add_aa = v1x_r; use_mul = 1'b1; add_nb = 1'b1;
      end
      fjvs_pkg::S_S26: begin
        ma = im1_q; mb = ly_r; add_aa = v1y_r; use_mul = 1'b1; add_nb = 1'b1;
      end
      fjvs_pkg::S_S27: begin
        ma = ii1_q; mb = t0_r; add_aa = w1_r; use_mul = 1'b1; add_nb = 1'b1;
      end
      fjvs_pkg::S_S28: begin
        ma = im2_q; mb = lx_r; add_aa = v2x_r; use_mul = 1'b1;
      end
      fjvs_pkg::S_S29: begin
        ma = im2_q; mb = ly_r; add_aa = v2y_r; use_mul = 1'b1;
      end
      fjvs_pkg::S_TQ: begin
        add_aa = acc_ang_r; add_ab = alev_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fjvs_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      off_x_r     <= '0;
      off_y_r     <= '0;
      im1_r       <= '0;
      im2_r       <= '0;
      ii1_r       <= '0;
      ii2_r       <= '0;
      acc_ang_r   <= '0;
      alx_r       <= '0;
      aly_r       <= '0;
      alev_r      <= '0;
      eff_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready && state_r != fjvs_pkg::S_TQ) out_valid_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          fjvs_pkg::CFG_OFFSET_X:      off_x_r <= cfg_data;
          fjvs_pkg::CFG_OFFSET_Y:      off_y_r <= cfg_data;
          fjvs_pkg::CFG_INV_MASS_1:    im1_r   <= cfg_data[30:0];
          fjvs_pkg::CFG_INV_MASS_2:    im2_r   <= cfg_data[30:0];
          fjvs_pkg::CFG_INV_INERTIA_1: ii1_r   <= cfg_data[30:0];
          fjvs_pkg::CFG_INV_INERTIA_2: ii2_r   <= cfg_data[30:0];
          default: ;
        endcase
      end
      case (state_r)
        fjvs_pkg::S_IDLE: begin
          if (in_acc) begin
            v1x_r <= in_tdata[31:0];
            v1y_r <= in_tdata[63:32];
            w1_r  <= in_tdata[95:64];
            v2x_r <= in_tdata[127:96];
            v2y_r <= in_tdata[159:128];
            w2_r  <= in_tdata[191:160];
            ang_r <= in_tdata[207:192];
            cmd_r <= in_tuser;
          end
        end
        fjvs_pkg::S_E_RND: begin
          eff_r <= (isum == 32'd0) ? 32'sd0 : eff_val;
          if (cmd_r == fjvs_pkg::CMD_CLEAR) begin
            acc_ang_r <= '0;
            alx_r     <= '0;
            aly_r     <= '0;
            alev_r    <= '0;
          end
        end
        fjvs_pkg::S_W1: w1_r <= add_res;
        fjvs_pkg::S_W2: begin
          w2_r  <= add_res;
          cos_r <= 1'b0;
        end
        fjvs_pkg::S_T0: begin
          x_r   <= {trig_f, 2'b00};
          neg_r <= trig_a[15];
        end
        fjvs_pkg::S_T1: t0_r <= add_res;
        fjvs_pkg::S_T2: t1_r <= add_res;
        fjvs_pkg::S_T3: t1_r <= add_res;
        fjvs_pkg::S_T4: begin
          if (cos_r) begin
            cs_r  <= add_res;
            cos_r <= 1'b0;
          end else begin
            sn_r  <= add_res;
            cos_r <= 1'b1;
          end
        end
        fjvs_pkg::S_L1:  t0_r <= add_res;
        fjvs_pkg::S_L2:  ax_r <= add_res;
        fjvs_pkg::S_L3:  t0_r <= add_res;
        fjvs_pkg::S_L4:  ay_r <= add_res;
        fjvs_pkg::S_W3:  v1x_r <= add_res;
        fjvs_pkg::S_W4:  v1y_r <= add_res;
        fjvs_pkg::S_W5:  t0_r <= add_res;
        fjvs_pkg::S_W6:  t0_r <= add_res;
        fjvs_pkg::S_W7:  w1_r <= add_res;
        fjvs_pkg::S_W8:  v2x_r <= add_res;
        fjvs_pkg::S_W9:  v2y_r <= add_res;
        fjvs_pkg::S_S1:  t0_r <= add_res;
        fjvs_pkg::S_S2:  la_r <= add_res;
        fjvs_pkg::S_S3:  acc_ang_r <= add_res;
        fjvs_pkg::S_S4:  w1_r <= add_res;
        fjvs_pkg::S_S5: begin
          w2_r  <= add_res;
          cos_r <= 1'b0;
        end
        fjvs_pkg::S_S6:  t0_r <= add_res;
        fjvs_pkg::S_S7:  t0_r <= add_res;
        fjvs_pkg::S_S8:  t1_r <= add_res;
        fjvs_pkg::S_S9:  t1_r <= add_res;
        fjvs_pkg::S_S10: t2_r <= add_res;
        fjvs_pkg::S_S11: t2_r <= add_res;
        fjvs_pkg::S_S12: t2_r <= add_res;
        fjvs_pkg::S_S13: t3_r <= add_res;
        fjvs_pkg::S_S14: t3_r <= add_res;
        fjvs_pkg::S_S15: t3_r <= add_res;
        fjvs_pkg::S_DX_START: begin
          if (!(t2_r > 32'sd0)) lx_r <= '0;
        end
        fjvs_pkg::S_DX_WAIT: begin
          if (div_stat.done) lx_r <= qdiv_sat(div_quo, neg_x);
        end
        fjvs_pkg::S_DY_START: begin
          if (!(t3_r > 32'sd0)) ly_r <= '0;
        end
        fjvs_pkg::S_DY_WAIT: begin
          if (div_stat.done) ly_r <= qdiv_sat(div_quo, neg_y);
        end
        fjvs_pkg::S_S20: alx_r <= add_res;
        fjvs_pkg::S_S21: aly_r <= add_res;
        fjvs_pkg::S_S22: t0_r <= add_res;
        fjvs_pkg::S_S23: t0_r <= add_res;
        fjvs_pkg::S_S24: alev_r <= add_res;
        fjvs_pkg::S_S25: v1x_r <= add_res;
        fjvs_pkg::S_S26: v1y_r <= add_res;
        fjvs_pkg::S_S27: w1_r <= add_res;
        fjvs_pkg::S_S28: v2x_r <= add_res;
        fjvs_pkg::S_S29: v2y_r <= add_res;
        fjvs_pkg::S_TQ: begin
          if (out_free) begin
            out_data_r  <= {add_res, aly_r, alx_r, w2_r, v2y_r, v2x_r, w1_r, v1y_r, v1x_r};
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == fjvs_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

endmodule

@@ rtl/fjvs_checker.sv @@
// port-level checks of the fixed joint velocity solver, bound to the top level
module fjvs_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [207:0] in_tdata,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [287:0] out_tdata,
  input logic         cfg_valid,
  input logic         cfg_ready,
  input logic [2:0]   cfg_index,
  input logic [31:0]  cfg_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in work");

  // a result only appears at the end of work
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while idle");

  // reset leaves the block idle and empty
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind fixed_joint_velocity_solver_top fjvs_checker u_fjvs_checker (.*);

@@ verif/tb.sv @@
// self-checking testbench of the fixed joint velocity solver, predicting every result beat
`timescale 1ns / 1ps
module tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [207:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [287:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  fixed_joint_velocity_solver_top dut (.*);

  always #6 clk = ~clk;

  typedef struct {
    logic [1:0] cmd;
    longint v [6];
    logic [15:0] ang;
  } joint_in_t;

  // joint model state
  longint m_ofs_x, m_ofs_y, m_im1, m_im2, m_ii1, m_ii2;
  longint m_ang_acc, m_lin_x, m_lin_y, m_lev_acc, m_eff;

  logic [287:0] vel_queue[$];
  int errors = 0;
  int n_sent = 0;
  int n_got = 0;
  int idle_cycles = 0;
  int rx_wait = 0;
  bit rx_hold = 1'b0;
  bit done_flag = 1'b0;

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint qm(longint a, longint b);
    longint p;
    p = a * b + 32768;
    if (p >= 0) return sat32(p >>> 16);
    return sat32(-((-p + 65535) >>> 16));
  endfunction

  function automatic longint qd(longint n, longint d);
    longint unsigned mag, q;
    if (d <= 0) return 0;
    mag = (n < 0) ? -n : n;
    q = ((mag << 16) + d / 2) / d;
    if (q > 64'h100000000) q = 64'h100000000;
    return sat32((n < 0) ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint qsin(longint f);
    longint x, x2, t;
    x = f * 4;
    x2 = (x * x) >>> 16;
    t = 42334 - ((x2 * 4926) >>> 16);
    t = 102944 - ((x2 * t) >>> 16);
    return (x * t) >>> 16;
  endfunction

  function automatic longint tsin(logic [15:0] a);
    longint f, b;
    f = a[13:0];
    b = a[14] ? qsin(16384 - f) : qsin(f);
    return a[15] ? -b : b;
  endfunction

  task automatic lever_arm(logic [15:0] a, output longint ax, output longint ay);
    longint s, c;
    s = tsin(a);
    c = tsin(a + 16'd16384);
    ax = sat32(-qm(s, m_ofs_x) - qm(c, m_ofs_y));
    ay = sat32(qm(c, m_ofs_x) - qm(s, m_ofs_y));
  endtask

  task automatic solve_joint(joint_in_t it, output logic [287:0] r);
    longint v1x, v1y, w1, v2x, v2y, w2, ax, ay, isum;
    longint la, cx, cy, dx, dy, lx, ly, lpa;
    longint unsigned q;
    v1x = it.v[0]; v1y = it.v[1]; w1 = it.v[2];
    v2x = it.v[3]; v2y = it.v[4]; w2 = it.v[5];
    if (it.cmd == fjvs_pkg::CMD_WARM || it.cmd == fjvs_pkg::CMD_CLEAR) begin
      isum = m_ii1 + m_ii2;
      if (isum <= 0) begin
        m_eff = 0;
      end else begin
        q = 64'h100000000 / isum;
        if ((64'h100000000 % isum) * 2 >= isum) q++;
        m_eff = sat32(longint'(q));
      end
      if (it.cmd == fjvs_pkg::CMD_WARM) begin
        w1 = sat32(w1 - qm(m_ii1, m_ang_acc));
        w2 = sat32(w2 + qm(m_ii2, m_ang_acc));
        lever_arm(it.ang, ax, ay);
        v1x = sat32(v1x - qm(m_im1, m_lin_x));
        v1y = sat32(v1y - qm(m_im1, m_lin_y));
        w1 = sat32(w1 - qm(m_ii1, sat32(qm(m_lin_x, ax) + qm(m_lin_y, ay))));
        v2x = sat32(v2x + qm(m_im2, m_lin_x));
        v2y = sat32(v2y + qm(m_im2, m_lin_y));
      end else begin
        m_ang_acc = 0; m_lin_x = 0; m_lin_y = 0; m_lev_acc = 0;
      end
    end else if (it.cmd == fjvs_pkg::CMD_SOLVE) begin
      la = sat32(-qm(m_eff, sat32(w2 - w1)));
      m_ang_acc = sat32(m_ang_acc + la);
      w1 = sat32(w1 - qm(m_ii1, la));
      w2 = sat32(w2 + qm(m_ii2, la));
      lever_arm(it.ang, ax, ay);
      cx = sat32(sat32(v2x - v1x) - qm(w1, ax));
      cy = sat32(sat32(v2y - v1y) - qm(w1, ay));
      dx = sat32(sat32(m_im1 + qm(qm(m_ii1, ax), ax)) + m_im2);
      dy = sat32(sat32(m_im1 + qm(qm(m_ii1, ay), ay)) + m_im2);
      lx = qd(-cx, dx);
      ly = qd(-cy, dy);
      m_lin_x = sat32(m_lin_x + lx);
      m_lin_y = sat32(m_lin_y + ly);
      lpa = sat32(qm(ax, lx) + qm(ay, ly));
      m_lev_acc = sat32(m_lev_acc + lpa);
      v1x = sat32(v1x - qm(m_im1, lx));
      v1y = sat32(v1y - qm(m_im1, ly));
      w1 = sat32(w1 - qm(m_ii1, lpa));
      v2x = sat32(v2x + qm(m_im2, lx));
      v2y = sat32(v2y + qm(m_im2, ly));
    end
    r = {32'(sat32(m_ang_acc + m_lev_acc)), 32'(m_lin_y), 32'(m_lin_x),
         32'(w2), 32'(v2y), 32'(v2x), 32'(w1), 32'(v1y), 32'(v1x)};
  endtask

  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  // valid stays up after an accept until the next gap or the end of a burst
  task automatic send_item(joint_in_t it, bit gaps = 1'b1);
    logic [287:0] r;
    int n;
    n = gaps ? $urandom_range(0, 19) : 0;
    if (n > 0) begin
      in_tvalid <= 1'b0;
      wait_cycles(n);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.cmd;
    in_tdata <= {it.ang, 32'(it.v[5]), 32'(it.v[4]), 32'(it.v[3]),
                 32'(it.v[2]), 32'(it.v[1]), 32'(it.v[0])};
    do @(posedge clk); while (!in_tready);
    solve_joint(it, r);
    vel_queue.push_back(r);
    n_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (vel_queue.size() != 0) @(posedge clk);
    wait_cycles(160);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      fjvs_pkg::CFG_OFFSET_X: m_ofs_x = longint'(signed'(val));
      fjvs_pkg::CFG_OFFSET_Y: m_ofs_y = longint'(signed'(val));
      fjvs_pkg::CFG_INV_MASS_1: m_im1 = val[30:0];
      fjvs_pkg::CFG_INV_MASS_2: m_im2 = val[30:0];
      fjvs_pkg::CFG_INV_INERTIA_1: m_ii1 = val[30:0];
      fjvs_pkg::CFG_INV_INERTIA_2: m_ii2 = val[30:0];
      default: ;
    endcase
  endtask

  task automatic set_params(logic [31:0] ox, logic [31:0] oy, logic [31:0] a,
                            logic [31:0] b, logic [31:0] c, logic [31:0] d);
    write_reg(fjvs_pkg::CFG_OFFSET_X, ox);
    write_reg(fjvs_pkg::CFG_OFFSET_Y, oy);
    write_reg(fjvs_pkg::CFG_INV_MASS_1, a);
    write_reg(fjvs_pkg::CFG_INV_MASS_2, b);
    write_reg(fjvs_pkg::CFG_INV_INERTIA_1, c);
    write_reg(fjvs_pkg::CFG_INV_INERTIA_2, d);
    cfg_valid <= 1'b0;
  endtask

  function automatic longint rnd_q(int mode);
    case (mode)
      0: return longint'(signed'($urandom()));
      1: return longint'($urandom_range(0, 8)) * 65536 - 4 * 65536;
      default: return longint'(signed'(32'($urandom_range(0, 65535)) - 32768)) * 16;
    endcase
  endfunction

  function automatic joint_in_t rnd_item(logic [1:0] cmd);
    joint_in_t it;
    int mode;
    mode = $urandom_range(0, 2);
    it.cmd = cmd;
    foreach (it.v[i]) it.v[i] = rnd_q(mode);
    it.ang = $urandom();
    return it;
  endfunction

  function automatic joint_in_t fill_item(logic [1:0] cmd, longint val, logic [15:0] a);
    joint_in_t it;
    it.cmd = cmd;
    foreach (it.v[i]) it.v[i] = val;
    it.ang = a;
    return it;
  endfunction

  // checker of result beats
  always @(posedge clk) begin
    logic [287:0] exp_beat;
    if (rst_n && out_tvalid && out_tready) begin
      n_got <= n_got + 1;
      if (vel_queue.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual %h", $time, out_tdata);
        errors++;
      end else begin
        exp_beat = vel_queue.pop_front();
        for (int f = 0; f < 9; f++) begin
          if (exp_beat[f*32 +: 32] !== out_tdata[f*32 +: 32]) begin
            $display("%0t field %0d mismatch: expected %h, actual %h", $time, f,
                     exp_beat[f*32 +: 32], out_tdata[f*32 +: 32]);
            errors++;
          end
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    int w;
    if (rx_hold) begin
      out_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_tready <= (rx_wait == 1);
    end else if (out_tvalid && out_tready) begin
      w = $urandom_range(0, 19);
      rx_wait <= w;
      out_tready <= (w == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000 && !done_flag) begin
      $display("fixed_joint_velocity_solver_top regression: fail");
      $finish;
    end
  end

  task automatic test_directed();
    logic [15:0] angs [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000,
                              16'h3fff, 16'hffff, 16'h2000, 16'h7fff};
    // zero inertia and zero denominators at reset
    send_item(fill_item(fjvs_pkg::CMD_WARM, 0, 0));
    send_item(fill_item(fjvs_pkg::CMD_SOLVE, 65536, 16'h1234));
    send_item(fill_item(fjvs_pkg::CMD_UNUSED, 12345, 16'h5555));
    drain();
    set_params(32'h0001_0000, 32'hffff_8000, 32'h0001_0000, 32'h0000_8000,
               32'h0002_0000, 32'h0001_0000);
    for (int i = 0; i < 8; i++) begin
      send_item(fill_item(fjvs_pkg::CMD_SOLVE,
                          (i % 2) ? 64'sd2147483647 : -64'sd2147483648, angs[i]));
    end
    send_item(fill_item(fjvs_pkg::CMD_WARM, 3 * 65536, 16'h1000));
    send_item(fill_item(fjvs_pkg::CMD_UNUSED, -1, 16'hffff));
    send_item(fill_item(fjvs_pkg::CMD_CLEAR, 7, 16'h0));
    send_item(fill_item(fjvs_pkg::CMD_WARM, 7, 16'h0));
    drain();
    // extremes: huge masses and offsets
    set_params(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h7fff_ffff, 32'h7fff_ffff);
    for (int i = 0; i < 4; i++) send_item(rnd_item(fjvs_pkg::CMD_SOLVE));
    send_item(rnd_item(fjvs_pkg::CMD_WARM));
    send_item(fill_item(fjvs_pkg::CMD_SOLVE, 0, 16'h0000));
    drain();
    set_params(32'h0, 32'h0, 32'h1, 32'h0, 32'h1, 32'h0);
    send_item(rnd_item(fjvs_pkg::CMD_CLEAR));
    send_item(rnd_item(fjvs_pkg::CMD_SOLVE));
    send_item(rnd_item(fjvs_pkg::CMD_WARM));
    drain();
  endtask

  task automatic test_random(int phases);
    logic [31:0] p [6];
    int r;
    for (int ph = 0; ph < phases; ph++) begin
      foreach (p[i]) begin
        r = $urandom_range(0, 4);
        p[i] = (r == 0) ? $urandom() : (r == 1) ? 32'h0 :
               (i < 2) ? 32'(signed'($urandom_range(0, 262143)) - 131072) :
               32'($urandom_range(0, 196608));
      end
      set_params(p[0], p[1], p[2], p[3], p[4], p[5]);
      for (int k = 0; k < 28; k++) begin
        r = $urandom_range(0, 19);
        if (r == 0) send_item(rnd_item(fjvs_pkg::CMD_UNUSED));
        else if (r < 3) send_item(rnd_item(fjvs_pkg::CMD_CLEAR));
        else if (r < 5) send_item(rnd_item(fjvs_pkg::CMD_WARM));
        else send_item(rnd_item(fjvs_pkg::CMD_SOLVE), k % 7 != 0);
      end
      drain();
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        rx_hold = 1'b1;
        wait_cycles(1500);
        rx_hold = 1'b0;
      end
      for (int k = 0; k < 10; k++) send_item(rnd_item(fjvs_pkg::CMD_SOLVE), 1'b0);
    join
    in_tvalid <= 1'b0;
    while (vel_queue.size() != 0) @(posedge clk);
    for (int k = 0; k < 6; k++) begin
      send_item(rnd_item(k == 0 ? fjvs_pkg::CMD_CLEAR : fjvs_pkg::CMD_SOLVE));
    end
    drain();
  endtask

  initial begin
    m_ofs_x = 0; m_ofs_y = 0; m_im1 = 0; m_im2 = 0; m_ii1 = 0; m_ii2 = 0;
    m_ang_acc = 0; m_lin_x = 0; m_lin_y = 0; m_lev_acc = 0; m_eff = 0;
    wait_cycles(9);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(15);
    done_flag = 1'b1;
    $display("covered %0d input beats and %0d result beats over 18 register settings,",
             n_sent, n_got);
    $display("all commands, saturation extremes, zero inertia and output stalls");
    if (errors == 0 && vel_queue.size() == 0) begin
      $display("fixed_joint_velocity_solver_top regression: pass");
    end else begin
      $display("fixed_joint_velocity_solver_top regression: fail");
    end
    $finish;
  end

endmodule

@@ fixed_joint_velocity_solver_top.f @@
rtl/fjvs_pkg.sv
rtl/fjvs_div.sv
rtl/fixed_joint_velocity_solver_top.sv
rtl/fjvs_checker.sv
verif/tb.sv
